### hw/rtl/canonical_huffman_byte_decoder_defines.svh
// Assertion macros shared by the canonical Huffman byte decoder RTL.
`ifndef CANONICAL_HUFFMAN_BYTE_DECODER_DEFINES_SVH
`define CANONICAL_HUFFMAN_BYTE_DECODER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CAHD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define CAHD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/cahd_pkg.sv
// Types, constants and helpers of the canonical Huffman byte decoder.
package cahd_pkg;

  localparam int MAX_CODE_LEN = 15;
  localparam int NUM_SYMBOLS  = 256;
  localparam int LEN_W        = 4;
  localparam int NUM_LENS     = 16;
  localparam int CNT_W        = 9;
  localparam int SYM_W        = 8;
  localparam int SYM_AW       = 8;
  localparam int TBL_BYTES    = NUM_SYMBOLS / 2;
  localparam int TBL_AW       = 7;
  localparam int CODE_W       = 16;
  localparam int OIDX_W       = 9;
  localparam int KRAFT_W      = MAX_CODE_LEN + 9;
  localparam int TOTAL_W      = 32;
  localparam int BIT_W        = 3;
  localparam int NSYM_W       = 3;

  localparam logic [LEN_W-1:0]  MAX_LEN  = LEN_W'(MAX_CODE_LEN);
  localparam logic [TBL_AW-1:0] TBL_LAST = TBL_AW'(TBL_BYTES - 1);

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_LEN   = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;

  localparam logic [1:0] RK_SYMBOL = 2'd0;
  localparam logic [1:0] RK_DONE   = 2'd1;
  localparam logic [1:0] RK_ERROR  = 2'd2;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_TABLE = 2'd1;
  localparam logic [1:0] ERR_CODE  = 2'd2;
  localparam logic [1:0] ERR_TRUNC = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [SYM_W-1:0]   byte_value;
    logic [TOTAL_W-1:0] symbol_total;
    logic               end_of_stream;
  } in_req_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [SYM_W-1:0] symbol;
    logic [1:0]       error_code;
    logic             last;
  } out_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TABLE,
    ST_KRAFT,
    ST_CHECK,
    ST_SORT,
    ST_DATA,
    ST_BIT,
    ST_BYTE_END,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              clear;
    logic              wr;
    logic [TBL_AW-1:0] wr_addr;
    logic [SYM_W-1:0]  wr_byte;
    logic              init;
    logic              kraft;
    logic              sort;
  } tbl_ctl_t;

  typedef struct packed {
    logic kraft_done;
    logic sort_done;
    logic table_ok;
  } tbl_sts_t;

  typedef struct packed {
    logic               start;
    logic [TOTAL_W-1:0] total;
    logic               load;
    logic [SYM_W-1:0]   byte_value;
    logic               eos;
    logic               step;
  } walk_ctl_t;

  typedef struct packed {
    logic hit;
    logic final_sym;
    logic overlong;
    logic last_bit;
    logic full_byte;
    logic eos;
  } walk_sts_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [1:0] error_code;
    logic       last;
    logic       use_sym;
  } pend_t;

  function automatic pend_t mk_pend(input logic [1:0] rk, input logic [1:0] ec,
                                    input logic last, input logic use_sym);
    pend_t p;
    p.result_kind = rk;
    p.error_code  = ec;
    p.last        = last;
    p.use_sym     = use_sym;
    return p;
  endfunction

endpackage

### hw/rtl/cahd_table.sv
// Length store, per-length counts, Kraft/offset pass, canonical sort sweep, symbol RAM.
`include "canonical_huffman_byte_decoder_defines.svh"

module cahd_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cahd_pkg::tbl_ctl_t            ctl,
  input  logic [cahd_pkg::LEN_W-1:0]    lk_len,
  input  logic                          rd_en,
  input  logic [cahd_pkg::SYM_AW-1:0]   rd_addr,
  output cahd_pkg::tbl_sts_t            sts,
  output logic [cahd_pkg::CNT_W-1:0]    lk_cnt,
  output logic [cahd_pkg::SYM_W-1:0]    rd_sym
);

  localparam logic [cahd_pkg::KRAFT_W-1:0] KRAFT_FULL =
    cahd_pkg::KRAFT_W'(1) << cahd_pkg::MAX_CODE_LEN;

  logic [cahd_pkg::SYM_W-1:0]   lens_mem   [cahd_pkg::TBL_BYTES];
  logic [cahd_pkg::SYM_W-1:0]   sorted_mem [cahd_pkg::NUM_SYMBOLS];

  logic [cahd_pkg::CNT_W-1:0]   cnt_r   [cahd_pkg::NUM_LENS];
  logic [cahd_pkg::CNT_W-1:0]   cnt_nxt [cahd_pkg::NUM_LENS];
  logic [cahd_pkg::CNT_W-1:0]   offs_r  [cahd_pkg::NUM_LENS];
  logic                         bad_r, bad_nxt;
  logic [cahd_pkg::LEN_W-1:0]   len_r;
  logic [cahd_pkg::SYM_AW:0]    sym_r;
  logic [cahd_pkg::KRAFT_W-1:0] kraft_r;
  logic [cahd_pkg::CNT_W-1:0]   total_r;
  logic [cahd_pkg::SYM_W-1:0]   lens_q_r;
  logic [cahd_pkg::SYM_AW-1:0]  sym_d_r;
  logic                         sort_v_r;
  logic [cahd_pkg::SYM_W-1:0]   rd_sym_r;

  logic [cahd_pkg::LEN_W-1:0]   lo, hi, sort_len;
  logic [cahd_pkg::CNT_W-1:0]   kcnt;
  logic                         sort_wr;

  assign lo       = ctl.wr_byte[cahd_pkg::LEN_W-1:0];
  assign hi       = ctl.wr_byte[cahd_pkg::SYM_W-1:cahd_pkg::LEN_W];
  assign kcnt     = cnt_r[len_r];
  assign sort_len = sym_d_r[0] ? lens_q_r[cahd_pkg::SYM_W-1:cahd_pkg::LEN_W]
                               : lens_q_r[cahd_pkg::LEN_W-1:0];
  assign sort_wr  = sort_v_r && (sort_len != '0);

  assign lk_cnt = cnt_r[lk_len];
  assign rd_sym = rd_sym_r;

  assign sts.kraft_done = ctl.kraft && (len_r == cahd_pkg::MAX_LEN);
  assign sts.sort_done  = sym_r[cahd_pkg::SYM_AW];
  assign sts.table_ok   = !bad_r && (kraft_r <= KRAFT_FULL) && (total_r != '0);

  always_comb begin
    for (int l = 0; l < cahd_pkg::NUM_LENS; l++) begin
      if (ctl.clear || l == 0) begin
        cnt_nxt[l] = '0;
      end else if (ctl.wr) begin
        cnt_nxt[l] = cnt_r[l] + cahd_pkg::CNT_W'(lo == cahd_pkg::LEN_W'(l))
                              + cahd_pkg::CNT_W'(hi == cahd_pkg::LEN_W'(l));
      end else begin
        cnt_nxt[l] = cnt_r[l];
      end
    end
    if (ctl.clear) begin
      bad_nxt = 1'b0;
    end else if (ctl.wr) begin
      bad_nxt = bad_r || (lo > cahd_pkg::MAX_LEN) || (hi > cahd_pkg::MAX_LEN);
    end else begin
      bad_nxt = bad_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < cahd_pkg::NUM_LENS; l++) begin
        cnt_r[l] <= '0;
      end
      bad_r    <= 1'b0;
      len_r    <= cahd_pkg::LEN_W'(1);
      sym_r    <= '0;
      kraft_r  <= '0;
      total_r  <= '0;
      sort_v_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      bad_r    <= bad_nxt;
      sort_v_r <= ctl.sort && !sym_r[cahd_pkg::SYM_AW];
      if (ctl.init) begin
        len_r   <= cahd_pkg::LEN_W'(1);
        sym_r   <= '0;
        kraft_r <= '0;
        total_r <= '0;
      end else if (ctl.kraft) begin
        // Horner form of sum(count[l] << (max - l))
        kraft_r <= {kraft_r[cahd_pkg::KRAFT_W-2:0], 1'b0} + cahd_pkg::KRAFT_W'(kcnt);
        total_r <= total_r + kcnt;
        len_r   <= len_r + cahd_pkg::LEN_W'(1);
      end else if (ctl.sort && !sym_r[cahd_pkg::SYM_AW]) begin
        sym_r <= sym_r + (cahd_pkg::SYM_AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.kraft) begin
      offs_r[len_r] <= total_r;
    end else if (sort_wr) begin
      offs_r[sort_len] <= offs_r[sort_len] + cahd_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      lens_mem[ctl.wr_addr] <= ctl.wr_byte;
    end
    lens_q_r <= lens_mem[sym_r[cahd_pkg::SYM_AW-1:1]];
    sym_d_r  <= sym_r[cahd_pkg::SYM_AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (sort_wr) begin
      sorted_mem[offs_r[sort_len][cahd_pkg::SYM_AW-1:0]] <= sym_d_r;
    end
    if (rd_en) begin
      rd_sym_r <= sorted_mem[rd_addr];
    end
  end

  `CAHD_ASSERT_NOW(a_sort_in_range, sort_wr, offs_r[sort_len] < total_r, "sort slot past symbol total")
  `CAHD_ASSERT_NOW(a_pass_exclusive, ctl.kraft, !ctl.sort && !ctl.wr, "length pass overlaps sort or fill")

endmodule

### hw/rtl/cahd_walk.sv
// Bit-serial canonical first/index walk over one data byte.
`include "canonical_huffman_byte_decoder_defines.svh"

module cahd_walk (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cahd_pkg::walk_ctl_t           ctl,
  input  logic [cahd_pkg::CNT_W-1:0]    lk_cnt,
  output logic [cahd_pkg::LEN_W-1:0]    lk_len,
  output logic [cahd_pkg::SYM_AW-1:0]   rd_addr,
  output cahd_pkg::walk_sts_t           sts
);

  logic [cahd_pkg::CODE_W-1:0]  partial_r, first_r;
  logic [cahd_pkg::OIDX_W-1:0]  oidx_r;
  logic [cahd_pkg::LEN_W-1:0]   clen_r;
  logic [cahd_pkg::TOTAL_W-1:0] remain_r;
  logic [cahd_pkg::BIT_W-1:0]   bit_r;
  logic [cahd_pkg::SYM_W-1:0]   byte_r;
  logic                         eos_r;
  logic [cahd_pkg::NSYM_W-1:0]  nsym_r;

  logic [cahd_pkg::CODE_W-1:0]  cand, first_sum;
  logic [cahd_pkg::CODE_W:0]    diff;
  logic [cahd_pkg::LEN_W:0]     clen_inc;
  logic                         hit, overlong;

  always_comb begin
    cand      = partial_r | cahd_pkg::CODE_W'(byte_r[bit_r]);
    diff      = {1'b0, cand} - {1'b0, first_r};
    hit       = !diff[cahd_pkg::CODE_W]
                && (diff[cahd_pkg::CODE_W-1:0] < cahd_pkg::CODE_W'(lk_cnt));
    first_sum = first_r + cahd_pkg::CODE_W'(lk_cnt);
    clen_inc  = {1'b0, clen_r} + (cahd_pkg::LEN_W + 1)'(1);
    overlong  = clen_inc > (cahd_pkg::LEN_W + 1)'(cahd_pkg::MAX_CODE_LEN);
  end

  assign lk_len  = clen_r;
  assign rd_addr = oidx_r[cahd_pkg::SYM_AW-1:0] + diff[cahd_pkg::SYM_AW-1:0];

  assign sts.hit       = hit;
  assign sts.final_sym = remain_r == cahd_pkg::TOTAL_W'(1);
  assign sts.overlong  = !hit && overlong;
  assign sts.last_bit  = bit_r == '0;
  assign sts.full_byte = nsym_r == '1;
  assign sts.eos       = eos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      first_r   <= '0;
      oidx_r    <= '0;
      clen_r    <= cahd_pkg::LEN_W'(1);
      remain_r  <= '0;
      bit_r     <= '0;
      byte_r    <= '0;
      eos_r     <= 1'b0;
      nsym_r    <= '0;
    end else if (ctl.start) begin
      partial_r <= '0;
      first_r   <= '0;
      oidx_r    <= '0;
      clen_r    <= cahd_pkg::LEN_W'(1);
      remain_r  <= ctl.total;
    end else if (ctl.load) begin
      byte_r <= ctl.byte_value;
      eos_r  <= ctl.eos;
      bit_r  <= '1;
      nsym_r <= '0;
    end else if (ctl.step) begin
      bit_r <= bit_r - cahd_pkg::BIT_W'(1);
      if (hit || overlong) begin
        partial_r <= '0;
        first_r   <= '0;
        oidx_r    <= '0;
        clen_r    <= cahd_pkg::LEN_W'(1);
        if (hit) begin
          remain_r <= remain_r - cahd_pkg::TOTAL_W'(1);
          nsym_r   <= nsym_r + cahd_pkg::NSYM_W'(1);
        end
      end else begin
        oidx_r    <= oidx_r + cahd_pkg::OIDX_W'(lk_cnt);
        first_r   <= {first_sum[cahd_pkg::CODE_W-2:0], 1'b0};
        partial_r <= {cand[cahd_pkg::CODE_W-2:0], 1'b0};
        clen_r    <= clen_inc[cahd_pkg::LEN_W-1:0];
      end
    end
  end

  `CAHD_ASSERT_NOW(a_clen_range, 1'b1, clen_r != '0 && clen_r <= cahd_pkg::MAX_LEN, "code length out of range")
  `CAHD_ASSERT_NEXT(a_hit_restart, ctl.step && !ctl.start && !ctl.load && hit, clen_r == cahd_pkg::LEN_W'(1) && partial_r == '0, "walk not restarted after symbol")

endmodule

### hw/rtl/canonical_huffman_byte_decoder.sv
// Top level of the canonical Huffman byte decoder: sequencer and result register.
//
//  channel  dir  handshake            payload
//  in_      in   in_valid / in_stall  in_req  (cahd_pkg::in_req_t)
//  out_     out  out_valid / out_stall out_res (cahd_pkg::out_res_t)
//
// Start and length requests are handled as they are accepted; the last length byte adds
// a length pass, a check step and a sort sweep through the length RAM.
// A data byte is walked one bit per cycle through the shared compare/add walk unit,
// pausing for each decoded symbol, which waits on its RAM read in the emit step.
// Reset clears all control state; no RAM is cleared.
// A stalled result register holds the sequencer in its emit step.
`include "canonical_huffman_byte_decoder_defines.svh"

module canonical_huffman_byte_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cahd_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output cahd_pkg::out_res_t out_res
);

  cahd_pkg::state_t   state_r, state_nxt, ret_r, ret_nxt;
  cahd_pkg::pend_t    pend_r, pend_nxt;
  logic [cahd_pkg::TBL_AW-1:0] idx_r, idx_nxt;
  logic               tail_eos_r, tail_eos_nxt;
  logic               out_valid_r, out_valid_nxt;
  cahd_pkg::out_res_t out_r, out_nxt;

  cahd_pkg::tbl_ctl_t  tctl;
  cahd_pkg::tbl_sts_t  tsts;
  cahd_pkg::walk_ctl_t wctl;
  cahd_pkg::walk_sts_t wsts;
  logic [cahd_pkg::LEN_W-1:0]  lk_len;
  logic [cahd_pkg::CNT_W-1:0]  lk_cnt;
  logic [cahd_pkg::SYM_AW-1:0] rd_addr;
  logic [cahd_pkg::SYM_W-1:0]  rd_sym;
  logic                        rd_en;

  logic accept, slot_free, load_out;

  cahd_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (tctl),
    .lk_len  (lk_len),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .sts     (tsts),
    .lk_cnt  (lk_cnt),
    .rd_sym  (rd_sym)
  );

  cahd_walk u_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (wctl),
    .lk_cnt  (lk_cnt),
    .lk_len  (lk_len),
    .rd_addr (rd_addr),
    .sts     (wsts)
  );

  assign in_stall  = !(state_r == cahd_pkg::ST_IDLE || state_r == cahd_pkg::ST_TABLE
                       || state_r == cahd_pkg::ST_DATA);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign load_out  = (state_r == cahd_pkg::ST_EMIT) && slot_free;

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  always_comb begin
    state_nxt    = state_r;
    ret_nxt      = ret_r;
    pend_nxt     = pend_r;
    idx_nxt      = idx_r;
    tail_eos_nxt = tail_eos_r;
    rd_en        = 1'b0;

    tctl         = '0;
    tctl.wr_addr = idx_r;
    tctl.wr_byte = in_req.byte_value;

    wctl            = '0;
    wctl.total      = in_req.symbol_total;
    wctl.byte_value = in_req.byte_value;
    wctl.eos        = in_req.end_of_stream;

    unique case (state_r)
      cahd_pkg::ST_IDLE, cahd_pkg::ST_TABLE, cahd_pkg::ST_DATA: begin
        if (accept) begin
          if (in_req.kind == cahd_pkg::KIND_START) begin
            tctl.clear = 1'b1;
            wctl.start = 1'b1;
            idx_nxt    = '0;
            if (in_req.symbol_total == '0) begin
              pend_nxt  = cahd_pkg::mk_pend(cahd_pkg::RK_DONE, cahd_pkg::ERR_NONE,
                                            1'b1, 1'b0);
              ret_nxt   = cahd_pkg::ST_IDLE;
              state_nxt = cahd_pkg::ST_EMIT;
            end else if (in_req.end_of_stream) begin
              pend_nxt  = cahd_pkg::mk_pend(cahd_pkg::RK_ERROR, cahd_pkg::ERR_TABLE,
                                            1'b1, 1'b0);
              ret_nxt   = cahd_pkg::ST_IDLE;
              state_nxt = cahd_pkg::ST_EMIT;
            end else begin
              state_nxt = cahd_pkg::ST_TABLE;
            end
          end else if (in_req.kind == cahd_pkg::KIND_LEN
                       && state_r == cahd_pkg::ST_TABLE) begin
            tctl.wr = 1'b1;
            idx_nxt = idx_r + cahd_pkg::TBL_AW'(1);
            if (idx_r == cahd_pkg::TBL_LAST) begin
              tctl.init    = 1'b1;
              tail_eos_nxt = in_req.end_of_stream;
              state_nxt    = cahd_pkg::ST_KRAFT;
            end else if (in_req.end_of_stream) begin
              pend_nxt  = cahd_pkg::mk_pend(cahd_pkg::RK_ERROR, cahd_pkg::ERR_TABLE,
                                            1'b1, 1'b0);
              ret_nxt   = cahd_pkg::ST_IDLE;
              state_nxt = cahd_pkg::ST_EMIT;
            end
          end else if (in_req.kind == cahd_pkg::KIND_DATA
                       && state_r == cahd_pkg::ST_DATA) begin
            wctl.load = 1'b1;
            state_nxt = cahd_pkg::ST_BIT;
          end
        end
      end
      cahd_pkg::ST_KRAFT: begin
        tctl.kraft = 1'b1;
        if (tsts.kraft_done) begin
          state_nxt = cahd_pkg::ST_CHECK;
        end
      end
      cahd_pkg::ST_CHECK: begin
        if (!tsts.table_ok) begin
          pend_nxt  = cahd_pkg::mk_pend(cahd_pkg::RK_ERROR, cahd_pkg::ERR_TABLE,
                                        1'b1, 1'b0);
          ret_nxt   = cahd_pkg::ST_IDLE;
          state_nxt = cahd_pkg::ST_EMIT;
        end else if (tail_eos_r) begin
          pend_nxt  = cahd_pkg::mk_pend(cahd_pkg::RK_ERROR, cahd_pkg::ERR_TRUNC,
                                        1'b1, 1'b0);
          ret_nxt   = cahd_pkg::ST_IDLE;
          state_nxt = cahd_pkg::ST_EMIT;
        end else begin
          state_nxt = cahd_pkg::ST_SORT;
        end
      end
      cahd_pkg::ST_SORT: begin
        tctl.sort = 1'b1;
        if (tsts.sort_done) begin
          state_nxt = cahd_pkg::ST_DATA;
        end
      end
      cahd_pkg::ST_BIT: begin
        wctl.step = 1'b1;
        if (wsts.hit) begin
          rd_en     = 1'b1;
          state_nxt = cahd_pkg::ST_EMIT;
          if (wsts.final_sym) begin
            pend_nxt = cahd_pkg::mk_pend(cahd_pkg::RK_SYMBOL, cahd_pkg::ERR_NONE,
                                         1'b1, 1'b1);
            ret_nxt  = cahd_pkg::ST_IDLE;
          end else if (wsts.last_bit && wsts.eos && wsts.full_byte) begin
            // eighth symbol of a short final byte gives way to the error
            pend_nxt = cahd_pkg::mk_pend(cahd_pkg::RK_ERROR, cahd_pkg::ERR_TRUNC,
                                         1'b1, 1'b0);
            ret_nxt  = cahd_pkg::ST_IDLE;
          end else begin
            pend_nxt = cahd_pkg::mk_pend(cahd_pkg::RK_SYMBOL, cahd_pkg::ERR_NONE,
                                         1'b0, 1'b1);
            ret_nxt  = wsts.last_bit ? cahd_pkg::ST_BYTE_END : cahd_pkg::ST_BIT;
          end
        end else if (wsts.overlong) begin
          pend_nxt  = cahd_pkg::mk_pend(cahd_pkg::RK_ERROR, cahd_pkg::ERR_CODE,
                                        1'b1, 1'b0);
          ret_nxt   = cahd_pkg::ST_IDLE;
          state_nxt = cahd_pkg::ST_EMIT;
        end else if (wsts.last_bit) begin
          state_nxt = cahd_pkg::ST_BYTE_END;
        end
      end
      cahd_pkg::ST_BYTE_END: begin
        if (wsts.eos) begin
          pend_nxt  = cahd_pkg::mk_pend(cahd_pkg::RK_ERROR, cahd_pkg::ERR_TRUNC,
                                        1'b1, 1'b0);
          ret_nxt   = cahd_pkg::ST_IDLE;
          state_nxt = cahd_pkg::ST_EMIT;
        end else begin
          state_nxt = cahd_pkg::ST_DATA;
        end
      end
      cahd_pkg::ST_EMIT: begin
        if (slot_free) begin
          state_nxt = ret_r;
        end
      end
      default: begin
        state_nxt = cahd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = load_out || (out_valid_r && out_stall);
    out_nxt       = out_r;
    if (load_out) begin
      out_nxt.result_kind = pend_r.result_kind;
      out_nxt.symbol      = pend_r.use_sym ? rd_sym : '0;
      out_nxt.error_code  = pend_r.error_code;
      out_nxt.last        = pend_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cahd_pkg::ST_IDLE;
      ret_r       <= cahd_pkg::ST_IDLE;
      pend_r      <= '0;
      idx_r       <= '0;
      tail_eos_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      pend_r      <= pend_nxt;
      idx_r       <= idx_nxt;
      tail_eos_r  <= tail_eos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  `CAHD_ASSERT_NEXT(a_emit_hold, state_r == cahd_pkg::ST_EMIT && out_valid_r && out_stall, state_r == cahd_pkg::ST_EMIT, "emit step left while result stalled")
  `CAHD_ASSERT_NEXT(a_empty_done, accept && in_req.kind == cahd_pkg::KIND_START && in_req.symbol_total == '0, state_r == cahd_pkg::ST_EMIT && pend_r.result_kind == cahd_pkg::RK_DONE, "empty stream marker not queued")

endmodule

### tb/canonical_huffman_byte_decoder_test.sv
// Testbench for canonical_huffman_byte_decoder: directed rows and random streams vs a predictor.
module canonical_huffman_byte_decoder_test;
  import cahd_pkg::*;

  localparam logic [1:0] KIND_BAD = 2'd3;
  localparam int RANDOM_ITEMS = 470;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 400;
  localparam int MAX_REPORTS  = 10;
  localparam int KRAFT_FULL   = 1 << MAX_CODE_LEN;

  typedef enum logic [1:0] {DEC_IDLE, DEC_TABLE, DEC_DATA} dec_phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [31:0] total;
    logic        eos;
    logic [7:0]  reps;
    logic        typed;
    logic [1:0]  exp_kind;
    logic [1:0]  exp_code;
  } dir_row_t;

  localparam int NUM_ROWS = 46;
  localparam dir_row_t DIR_ROWS [NUM_ROWS] = '{
    '{KIND_START, 8'h00, 32'd0,          1'b0, 8'd1,   1'b1, RK_DONE,   ERR_NONE},
    '{KIND_START, 8'h00, 32'd5,          1'b1, 8'd1,   1'b1, RK_ERROR,  ERR_TABLE},
    '{KIND_LEN,   8'h88, 32'd0,          1'b0, 8'd1,   1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_START, 8'h00, 32'd3,          1'b0, 8'd1,   1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_DATA,  8'hFF, 32'd0,          1'b0, 8'd1,   1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_LEN,   8'h88, 32'd0,          1'b0, 8'd10,  1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_LEN,   8'h88, 32'd0,          1'b1, 8'd1,   1'b1, RK_ERROR,  ERR_TABLE},
    '{KIND_START, 8'h00, 32'd3,          1'b0, 8'd1,   1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_LEN,   8'h00, 32'd0,          1'b0, 8'd128, 1'b1, RK_ERROR,  ERR_TABLE},
    '{KIND_START, 8'h00, 32'd7,          1'b0, 8'd1,   1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_LEN,   8'h44, 32'd0,          1'b0, 8'd5,   1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_START, 8'h00, 32'd3,          1'b0, 8'd1,   1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_LEN,   8'h11, 32'd0,          1'b0, 8'd128, 1'b1, RK_ERROR,  ERR_TABLE},
    '{KIND_START, 8'h00, 32'd3,          1'b0, 8'd1,   1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_LEN,   8'h88, 32'd0,          1'b0, 8'd127, 1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_LEN,   8'h88, 32'd0,          1'b1, 8'd1,   1'b1, RK_ERROR,  ERR_TRUNC},
    '{KIND_START, 8'h00, 32'hFFFF_FFFF,  1'b0, 8'd1,   1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_LEN,   8'hFF, 32'd0,          1'b0, 8'd1,   1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_LEN,   8'h88, 32'd0,          1'b0, 8'd127, 1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_DATA,  8'h00, 32'd0,          1'b0, 8'd1,   1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_DATA,  8'hFD, 32'd0,          1'b0, 8'd1,   1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_DATA,  8'hFE, 32'd0,          1'b0, 8'd1,   1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_DATA,  8'h00, 32'd0,          1'b0, 8'd1,   1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_LEN,   8'h5A, 32'd0,          1'b1, 8'd1,   1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_DATA,  8'h5A, 32'd0,          1'b1, 8'd1,   1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_DATA,  8'h00, 32'd0,          1'b0, 8'd1,   1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_START, 8'h00, 32'd100,        1'b0, 8'd1,   1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_LEN,   8'h11, 32'd0,          1'b0, 8'd1,   1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_LEN,   8'h00, 32'd0,          1'b0, 8'd127, 1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_DATA,  8'hAA, 32'd0,          1'b1, 8'd1,   1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_START, 8'h00, 32'd10,         1'b0, 8'd1,   1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_LEN,   8'h01, 32'd0,          1'b0, 8'd1,   1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_LEN,   8'h00, 32'd0,          1'b0, 8'd127, 1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_DATA,  8'h00, 32'd0,          1'b0, 8'd1,   1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_DATA,  8'hFF, 32'd0,          1'b0, 8'd1,   1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_DATA,  8'hFF, 32'd0,          1'b0, 8'd1,   1'b1, RK_ERROR,  ERR_CODE},
    '{KIND_START, 8'h00, 32'd3,          1'b0, 8'd1,   1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_LEN,   8'h11, 32'd0,          1'b0, 8'd1,   1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_LEN,   8'h00, 32'd0,          1'b0, 8'd127, 1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_DATA,  8'h4F, 32'd0,          1'b0, 8'd1,   1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_START, 8'h00, 32'd9,          1'b0, 8'd1,   1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_LEN,   8'h11, 32'd0,          1'b0, 8'd1,   1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_LEN,   8'h00, 32'd0,          1'b0, 8'd127, 1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_DATA,  8'h12, 32'd0,          1'b0, 8'd1,   1'b0, RK_SYMBOL, ERR_NONE},
    '{KIND_START, 8'h00, 32'd0,          1'b0, 8'd1,   1'b1, RK_DONE,   ERR_NONE},
    '{KIND_BAD,   8'h55, 32'd0,          1'b0, 8'd1,   1'b0, RK_SYMBOL, ERR_NONE}
  };

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_res_t out_res;

  int cycles = 0;
  int accepted_items = 0;
  int dir_items = 0;
  int streams = 0;
  int mismatches = 0;
  int results_seen = 0;
  int symbols_seen = 0;
  int errors_seen = 0;
  int done_seen = 0;
  logic calm;

  // decoder image
  logic [LEN_W-1:0]  sym_len [NUM_SYMBOLS];
  logic [CNT_W-1:0]  len_count [NUM_LENS];
  logic [SYM_W-1:0]  canon_order [NUM_SYMBOLS];
  logic [31:0]       syms_left = '0;
  int                table_fill = 0;
  dec_phase_t        phase = DEC_IDLE;
  logic [CODE_W-1:0] code_acc = '0;
  logic [CODE_W-1:0] code_base = '0;
  logic [OIDX_W-1:0] base_index = '0;
  logic [4:0]        code_len = 5'd1;

  out_res_t step_results [$];
  out_res_t expected_results [$];

  canonical_huffman_byte_decoder u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res(out_res)
  );

  always #5 clk = ~clk;

  assign calm = (cycles >= 4000 && cycles < 7000);

  function automatic out_res_t mk_res(logic [1:0] rk, logic [7:0] sym, logic [1:0] ec,
                                      logic last);
    out_res_t r;
    r.result_kind = rk;
    r.symbol      = sym;
    r.error_code  = ec;
    r.last        = last;
    return r;
  endfunction

  task automatic restart_walk();
    code_acc   = '0;
    code_base  = '0;
    base_index = '0;
    code_len   = 5'd1;
  endtask

  task automatic decode_request(input in_req_t r);
    int cnt;
    int diff;
    int kraft;
    int filled;
    step_results.delete();
    if (r.kind == KIND_START) begin
      restart_walk();
      table_fill = 0;
      syms_left = r.symbol_total;
      if (r.symbol_total == '0) begin
        phase = DEC_IDLE;
        step_results.push_back(mk_res(RK_DONE, 8'h00, ERR_NONE, 1'b1));
      end else if (r.end_of_stream) begin
        phase = DEC_IDLE;
        step_results.push_back(mk_res(RK_ERROR, 8'h00, ERR_TABLE, 1'b1));
      end else begin
        phase = DEC_TABLE;
      end
    end else if (r.kind == KIND_LEN && phase == DEC_TABLE) begin
      sym_len[2*table_fill]   = r.byte_value[3:0];
      sym_len[2*table_fill+1] = r.byte_value[7:4];
      table_fill++;
      if (table_fill < TBL_BYTES) begin
        if (r.end_of_stream) begin
          phase = DEC_IDLE;
          step_results.push_back(mk_res(RK_ERROR, 8'h00, ERR_TABLE, 1'b1));
        end
      end else begin
        foreach (len_count[l]) len_count[l] = '0;
        foreach (sym_len[s]) len_count[sym_len[s]]++;
        len_count[0] = '0;
        kraft = 0;
        filled = 0;
        for (int l = 1; l <= MAX_CODE_LEN; l++) begin
          kraft += int'(len_count[l]) << (MAX_CODE_LEN - l);
          for (int s = 0; s < NUM_SYMBOLS; s++)
            if (sym_len[s] == l) begin
              canon_order[filled] = 8'(s);
              filled++;
            end
        end
        restart_walk();
        phase = DEC_IDLE;
        if (kraft > KRAFT_FULL || filled == 0)
          step_results.push_back(mk_res(RK_ERROR, 8'h00, ERR_TABLE, 1'b1));
        else if (r.end_of_stream)
          step_results.push_back(mk_res(RK_ERROR, 8'h00, ERR_TRUNC, 1'b1));
        else
          phase = DEC_DATA;
      end
    end else if (r.kind == KIND_DATA && phase == DEC_DATA) begin
      for (int b = 7; b >= 0; b--) begin
        cnt = len_count[code_len[3:0]];
        code_acc = code_acc | CODE_W'(r.byte_value[b]);
        diff = int'(code_acc) - int'(code_base);
        if (diff >= 0 && diff < cnt) begin
          syms_left = syms_left - 1;
          if (syms_left == '0) begin
            step_results.push_back(mk_res(RK_SYMBOL, canon_order[8'(int'(base_index) + diff)],
                                          ERR_NONE, 1'b1));
            restart_walk();
            phase = DEC_IDLE;
            return;
          end
          step_results.push_back(mk_res(RK_SYMBOL, canon_order[8'(int'(base_index) + diff)],
                                        ERR_NONE, 1'b0));
          restart_walk();
        end else begin
          base_index = base_index + OIDX_W'(cnt);
          code_base  = (code_base + CODE_W'(cnt)) << 1;
          code_acc   = code_acc << 1;
          code_len++;
          if (code_len > MAX_CODE_LEN) begin
            restart_walk();
            phase = DEC_IDLE;
            step_results.push_back(mk_res(RK_ERROR, 8'h00, ERR_CODE, 1'b1));
            return;
          end
        end
      end
      if (r.end_of_stream) begin
        restart_walk();
        phase = DEC_IDLE;
        // a full byte of symbols gives up its eighth slot to the truncation error
        if (step_results.size() == 8) void'(step_results.pop_back());
        step_results.push_back(mk_res(RK_ERROR, 8'h00, ERR_TRUNC, 1'b1));
      end
    end
  endtask

  task automatic send_req(input in_req_t r, input bit typed, input out_res_t typed_res);
    while (!calm && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (r.kind == KIND_START || (r.kind == KIND_LEN && phase == DEC_TABLE) ||
        (r.kind == KIND_DATA && phase == DEC_DATA))
      accepted_items++;
    if (r.kind == KIND_START) streams++;
    decode_request(r);
    if (typed) begin
      step_results.delete();
      step_results.push_back(typed_res);
    end
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // a request the decoder drops in its present phase
  task automatic send_noise();
    in_req_t r;
    r = '0;
    r.byte_value    = 8'($urandom);
    r.symbol_total  = $urandom;
    r.end_of_stream = 1'($urandom);
    do r.kind = 2'($urandom_range(1, 3));
    while ((r.kind == KIND_LEN && phase == DEC_TABLE) ||
           (r.kind == KIND_DATA && phase == DEC_DATA));
    send_req(r, 1'b0, '0);
  endtask

  task automatic send_random_stream();
    logic [LEN_W-1:0] gen_len [NUM_SYMBOLS];
    in_req_t r;
    int pick;
    int kraft;
    int l;
    int lo;
    int dens;
    int stop_at;
    int nbytes;
    bit fill;
    bit stop_eos;
    bit eos_at_end;
    pick = $urandom_range(0, 99);
    r = '0;
    r.kind = KIND_START;
    r.byte_value = 8'($urandom);
    r.symbol_total = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 60);
    if (pick < 4) r.symbol_total = '0;
    r.end_of_stream = (pick >= 4 && pick < 8);
    send_req(r, 1'b0, '0);
    if (phase != DEC_TABLE) return;

    kraft = 0;
    foreach (gen_len[s]) gen_len[s] = '0;
    case ($urandom_range(0, 9))
      0: foreach (gen_len[s]) gen_len[s] = 4'd8;
      1: foreach (gen_len[s]) gen_len[s] = 4'($urandom_range(0, 15));
      2: ;
      default: begin
        lo   = $urandom_range(1, 12);
        dens = $urandom_range(5, 100);
        fill = 1'($urandom_range(0, 1));
        for (int pass = 0; pass < 2; pass++)
          foreach (gen_len[s]) begin
            if (gen_len[s] != 0) continue;
            if (pass == 0 ? $urandom_range(1, 100) > dens : !fill) continue;
            l = (pass == 0) ? $urandom_range(lo, MAX_CODE_LEN) : 1;
            while (l < MAX_CODE_LEN && kraft + (1 << (MAX_CODE_LEN - l)) > KRAFT_FULL) l++;
            if (kraft + (1 << (MAX_CODE_LEN - l)) <= KRAFT_FULL) begin
              gen_len[s] = 4'(l);
              kraft += 1 << (MAX_CODE_LEN - l);
            end
          end
      end
    endcase

    stop_at    = ($urandom_range(0, 99) < 12) ? $urandom_range(0, TBL_BYTES - 1) : TBL_BYTES;
    stop_eos   = 1'($urandom_range(0, 1));
    eos_at_end = ($urandom_range(0, 99) < 5);
    for (int i = 0; i < TBL_BYTES; i++) begin
      if ($urandom_range(0, 99) < 3) send_noise();
      r = '0;
      r.kind = KIND_LEN;
      r.byte_value = {gen_len[2*i+1], gen_len[2*i]};
      r.symbol_total = $urandom;
      r.end_of_stream = (i == stop_at && stop_eos) || (i == TBL_BYTES - 1 && eos_at_end);
      send_req(r, 1'b0, '0);
      if (i == stop_at) return;
    end

    nbytes = 0;
    while (phase == DEC_DATA) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) return;
      if (pick < 5) send_noise();
      r = '0;
      r.kind = KIND_DATA;
      r.byte_value = 8'($urandom);
      r.symbol_total = $urandom;
      r.end_of_stream = ($urandom_range(0, 99) < 4) || nbytes == 40;
      send_req(r, 1'b0, '0);
      nbytes++;
    end
    if ($urandom_range(0, 3) == 0) send_noise();
  endtask

  always @(posedge clk) begin : check_results
    out_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: kind %0d sym %02h err %0d last %0d",
                   out_res.result_kind, out_res.symbol, out_res.error_code, out_res.last);
      end else begin
        want = expected_results.pop_front();
        if (out_res !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %0d: expected kind %0d sym %02h err %0d last %0d, got kind %0d sym %02h err %0d last %0d",
                     results_seen, want.result_kind, want.symbol, want.error_code, want.last,
                     out_res.result_kind, out_res.symbol, out_res.error_code, out_res.last);
        end
        case (want.result_kind)
          RK_SYMBOL: symbols_seen++;
          RK_DONE:   done_seen++;
          default:   errors_seen++;
        endcase
      end
    end
    out_stall <= !calm && ($urandom_range(0, 99) < 30);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, expected_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    in_req_t r;
    out_res_t typed_res;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIR_ROWS[i]) begin
      r = '0;
      r.kind          = DIR_ROWS[i].kind;
      r.byte_value    = DIR_ROWS[i].byte_value;
      r.symbol_total  = DIR_ROWS[i].total;
      r.end_of_stream = DIR_ROWS[i].eos;
      typed_res = mk_res(DIR_ROWS[i].exp_kind, 8'h00, DIR_ROWS[i].exp_code, 1'b1);
      for (int k = 0; k < DIR_ROWS[i].reps; k++)
        send_req(r, DIR_ROWS[i].typed && k == DIR_ROWS[i].reps - 1, typed_res);
    end
    dir_items = accepted_items;
    wait_drained();

    while (accepted_items < dir_items + RANDOM_ITEMS) begin
      send_random_stream();
      if ($urandom_range(0, 9) == 0) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d streams over %0d decoded requests in %0d cycles",
             streams, accepted_items, cycles);
    $display("checked %0d results: %0d symbols, %0d errors, %0d empty-stream markers",
             results_seen, symbols_seen, errors_seen, done_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, expected_results.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/cahd_pkg.sv
hw/rtl/cahd_table.sv
hw/rtl/cahd_walk.sv
hw/rtl/canonical_huffman_byte_decoder.sv
tb/canonical_huffman_byte_decoder_test.sv
